>>> rtl/lbbs_pkg.sv
package lbbs_pkg;

   // Field widths
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned EFFECT_W = 3;
   localparam int unsigned PCT_W    = 7;
   localparam int unsigned PHASE_W  = 7;
   localparam int unsigned MS_W     = 16;
   localparam int unsigned STEP_W   = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Breathe phase runs 0..PHASE_TOP..0
   localparam int unsigned PHASE_TOP    = 100;
   localparam int unsigned EFFECT_COUNT = 6;
   localparam int unsigned LUT_DEPTH    = 2 ** PHASE_W;
   localparam int unsigned PCT_MAX      = 100;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEXT = 2'd2;

   // Effects
   localparam logic [EFFECT_W-1:0] EFF_OFF        = 3'd0;
   localparam logic [EFFECT_W-1:0] EFF_ON         = 3'd1;
   localparam logic [EFFECT_W-1:0] EFF_BLINK_SLOW = 3'd2;
   localparam logic [EFFECT_W-1:0] EFF_BLINK_MID  = 3'd3;
   localparam logic [EFFECT_W-1:0] EFF_BLINK_FAST = 3'd4;
   localparam logic [EFFECT_W-1:0] EFF_BREATHE    = 3'd5;
   localparam logic [EFFECT_W-1:0] EFF_LAST       = EFFECT_W'(EFFECT_COUNT - 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_SWITCH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BREATHE_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_SLOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_MID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_FAST  = 3'd4;

   // Register reset values
   localparam logic [MS_W-1:0]   AUTO_SWITCH_RST  = 16'd6000;
   localparam logic [STEP_W-1:0] BREATHE_STEP_RST = 8'd20;
   localparam logic [MS_W-1:0]   BLINK_SLOW_RST   = 16'd500;
   localparam logic [MS_W-1:0]   BLINK_MID_RST    = 16'd250;
   localparam logic [MS_W-1:0]   BLINK_FAST_RST   = 16'd100;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [EFFECT_W-1:0] effect_code;
   } req_type;

   typedef struct packed {
      logic                led_on;
      logic [PCT_W-1:0]    brightness_pct;
      logic                dim_mode;
      logic [EFFECT_W-1:0] active_effect;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic exec;      // apply the item to the effect state
      logic look;      // refresh brightness from the smoothstep table
      logic load;      // load the result register
   } ctl_type;

   typedef logic [PCT_W-1:0] lut_type [LUT_DEPTH];

   // Smoothstep brightness table, built at elaboration
   function automatic lut_type build_lut();
      lut_type     lut;
      logic [31:0] t;
      logic [31:0] num;
      logic [31:0] pct;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         t   = 32'(i);
         num = 32'd3 * t * t - (32'd2 * t * t * t) / 32'(PHASE_TOP) + 32'(PHASE_TOP / 2);
         pct = (num * 32'd100) / 32'(PHASE_TOP * PHASE_TOP);
         lut[i] = (pct > 32'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct[PCT_W-1:0];
      end
      return lut;
   endfunction

endpackage

>>> rtl/lbbs_ctrl.sv
module lbbs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lbbs_pkg::ctl_type ctl
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOOK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Command decode
   always_comb begin
      ctl.capture = accept;
      ctl.exec    = (state_ff == S_EXEC);
      ctl.look    = (state_ff == S_LOOK);
      ctl.load    = (state_ff == S_DONE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: state_in = S_LOOK;
         S_LOOK: state_in = S_DONE;
         S_DONE: if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctl.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item did not start execution");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while occupied");

endmodule

>>> rtl/lbbs_datapath.sv
module lbbs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  lbbs_pkg::ctl_type                   ctl,
   input  lbbs_pkg::req_type                   req_data,
   output lbbs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [lbbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lbbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam lbbs_pkg::lut_type SMOOTH_LUT = lbbs_pkg::build_lut();
   localparam logic [lbbs_pkg::MS_W-1:0] MS_SAT = '1;
   localparam logic [lbbs_pkg::PHASE_W-1:0] PHASE_TOP_V =
      lbbs_pkg::PHASE_W'(lbbs_pkg::PHASE_TOP);

   // Configuration registers
   logic [lbbs_pkg::MS_W-1:0]   auto_switch_ff;
   logic [lbbs_pkg::STEP_W-1:0] breathe_step_ff;
   logic [lbbs_pkg::MS_W-1:0]   blink_slow_ff, blink_mid_ff, blink_fast_ff;

   // Effect state
   logic [lbbs_pkg::EFFECT_W-1:0] effect_ff, effect_in;
   logic                          lamp_ff, lamp_in;
   logic [lbbs_pkg::MS_W-1:0]     since_upd_ff, since_upd_in;
   logic [lbbs_pkg::MS_W-1:0]     since_sw_ff, since_sw_in;
   logic [lbbs_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic                          falling_ff, falling_in;
   logic [lbbs_pkg::PCT_W-1:0]    bright_ff, bright_in;
   logic                          step_pend_ff, step_pend_in;

   lbbs_pkg::req_type item_ff;
   lbbs_pkg::rsp_type rsp_ff;

   // Scratch for the item update
   logic [lbbs_pkg::MS_W-1:0]     upd_inc, sw_inc, half;
   logic [lbbs_pkg::EFFECT_W-1:0] next_eff, start_eff;
   logic                          do_start, is_blink;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_switch_ff  <= lbbs_pkg::AUTO_SWITCH_RST;
         breathe_step_ff <= lbbs_pkg::BREATHE_STEP_RST;
         blink_slow_ff   <= lbbs_pkg::BLINK_SLOW_RST;
         blink_mid_ff    <= lbbs_pkg::BLINK_MID_RST;
         blink_fast_ff   <= lbbs_pkg::BLINK_FAST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lbbs_pkg::REG_AUTO_SWITCH:  auto_switch_ff  <= csr_wdata;
            lbbs_pkg::REG_BREATHE_STEP: breathe_step_ff <= csr_wdata[lbbs_pkg::STEP_W-1:0];
            lbbs_pkg::REG_BLINK_SLOW:   blink_slow_ff   <= csr_wdata;
            lbbs_pkg::REG_BLINK_MID:    blink_mid_ff    <= csr_wdata;
            lbbs_pkg::REG_BLINK_FAST:   blink_fast_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item capture
   always_ff @(posedge clock) begin
      if (ctl.capture) item_ff <= req_data;
   end

   // Saturating counters, next effect and blink half period
   always_comb begin
      upd_inc  = (since_upd_ff == MS_SAT) ? since_upd_ff : since_upd_ff + 1'b1;
      sw_inc   = (since_sw_ff == MS_SAT) ? since_sw_ff : since_sw_ff + 1'b1;
      next_eff = (effect_ff >= lbbs_pkg::EFF_LAST) ? lbbs_pkg::EFF_OFF
                                                   : effect_ff + 1'b1;
      is_blink = 1'b1;
      case (effect_ff)
         lbbs_pkg::EFF_BLINK_SLOW: half = blink_slow_ff;
         lbbs_pkg::EFF_BLINK_MID:  half = blink_mid_ff;
         lbbs_pkg::EFF_BLINK_FAST: half = blink_fast_ff;
         default: begin
            half     = '0;
            is_blink = 1'b0;
         end
      endcase
   end

   // Item update and brightness refresh
   always_comb begin
      effect_in    = effect_ff;
      lamp_in      = lamp_ff;
      since_upd_in = since_upd_ff;
      since_sw_in  = since_sw_ff;
      phase_in     = phase_ff;
      falling_in   = falling_ff;
      bright_in    = bright_ff;
      step_pend_in = step_pend_ff;
      do_start     = 1'b0;
      start_eff    = next_eff;

      if (ctl.exec) begin
         step_pend_in = 1'b0;
         case (item_ff.cmd)
            lbbs_pkg::CMD_TICK: begin
               since_upd_in = upd_inc;
               since_sw_in  = sw_inc;
               if (sw_inc >= auto_switch_ff) begin
                  do_start = 1'b1;
               end else if (effect_ff == lbbs_pkg::EFF_BREATHE) begin
                  if (upd_inc >= lbbs_pkg::MS_W'(breathe_step_ff)) begin
                     since_upd_in = '0;
                     step_pend_in = 1'b1;
                     if (!falling_ff) begin
                        if (phase_ff < PHASE_TOP_V) begin
                           phase_in = phase_ff + 1'b1;
                        end else begin
                           falling_in = 1'b1;
                           phase_in   = phase_ff - 1'b1;
                        end
                     end else begin
                        if (phase_ff != '0) begin
                           phase_in = phase_ff - 1'b1;
                        end else begin
                           falling_in = 1'b0;
                           phase_in   = phase_ff + 1'b1;
                        end
                     end
                  end
               end else if (is_blink && (upd_inc >= half)) begin
                  since_upd_in = '0;
                  lamp_in      = !lamp_ff;
               end
            end
            lbbs_pkg::CMD_SET: begin
               if (item_ff.effect_code <= lbbs_pkg::EFF_LAST) begin
                  do_start  = 1'b1;
                  start_eff = item_ff.effect_code;
               end
            end
            lbbs_pkg::CMD_NEXT: do_start = 1'b1;
            default: ;
         endcase

         // Effect restart
         if (do_start) begin
            effect_in    = start_eff;
            since_upd_in = '0;
            since_sw_in  = '0;
            if (start_eff == lbbs_pkg::EFF_ON) begin
               lamp_in = 1'b1;
            end else if (start_eff == lbbs_pkg::EFF_BREATHE) begin
               phase_in   = '0;
               falling_in = 1'b0;
               bright_in  = '0;
            end else begin
               lamp_in = 1'b0;
            end
         end
      end

      // Table read on the phase left by the step
      if (ctl.look && step_pend_ff) begin
         bright_in    = SMOOTH_LUT[phase_ff];
         step_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_ff    <= lbbs_pkg::EFF_OFF;
         lamp_ff      <= 1'b0;
         since_upd_ff <= '0;
         since_sw_ff  <= '0;
         phase_ff     <= '0;
         falling_ff   <= 1'b0;
         bright_ff    <= '0;
         step_pend_ff <= 1'b0;
      end else begin
         effect_ff    <= effect_in;
         lamp_ff      <= lamp_in;
         since_upd_ff <= since_upd_in;
         since_sw_ff  <= since_sw_in;
         phase_ff     <= phase_in;
         falling_ff   <= falling_in;
         bright_ff    <= bright_in;
         step_pend_ff <= step_pend_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rsp_ff.dim_mode       <= (effect_ff == lbbs_pkg::EFF_BREATHE);
         rsp_ff.led_on         <= (effect_ff == lbbs_pkg::EFF_BREATHE) ? 1'b0 : lamp_ff;
         rsp_ff.brightness_pct <= (effect_ff == lbbs_pkg::EFF_BREATHE) ? bright_ff : '0;
         rsp_ff.active_effect  <= effect_ff;
      end
   end

   assign rsp_data = rsp_ff;

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_TOP_V)
      else $error("breathe phase beyond top");

   a_effect_valid: assert property (@(posedge clock) disable iff (reset)
      effect_ff <= lbbs_pkg::EFF_LAST)
      else $error("effect code out of range");

   a_bright_after_step: assert property (@(posedge clock) disable iff (reset)
      (ctl.look && step_pend_ff) |=> bright_ff == SMOOTH_LUT[$past(phase_ff)])
      else $error("brightness not refreshed after phase step");

endmodule

>>> rtl/led_blink_breathe_sequencer_unit.sv
// LED effect sequencer: off, on, three blink rates and a smoothstep breathe.
// req channel (req_valid/req_ready/req_data): one item per command; cmd 0 is a
//   one-millisecond tick, cmd 1 sets effect_code, cmd 2 steps to the next effect.
// rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one result item per
//   request item, in order: LED drive, breathe brightness, dim flag, effect.
// csr port: csr_we writes csr_wdata into register csr_index (0 auto-switch,
//   1 breathe step, 2..4 blink half periods); write only while idle.
// Items are handled one at a time: the accept in idle, then the controller
//   walks execute, table lookup and result load before it returns to idle.
// The result sits in an output register, so the next request item is taken
//   while the previous result waits. If rsp_ready stays low the controller
//   holds in its load state and req_ready stays low until the register frees.
// Reset (synchronous, active high) restores the register defaults and leaves
//   the effect off with all counters and the breathe phase at zero.
module led_blink_breathe_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lbbs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lbbs_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [lbbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbbs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lbbs_pkg::ctl_type ctl;

   lbbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   lbbs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
